// File: sv/ssd_pkg.sv
// ssd_pkg: shared types, constants and lookup functions for the
// four-digit seven-segment display driver; no dependencies
package ssd_pkg;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned PtrW      = 2;

  typedef logic [7:0] seg_t;

  typedef enum logic [2:0] {
    OP_NUMBER = 3'd0,
    OP_DIGIT  = 3'd1,
    OP_BLANK  = 3'd2,
    OP_DASH   = 3'd3,
    OP_SCAN   = 3'd4
  } op_e;

  localparam seg_t SegBlank = 8'hFF;
  localparam seg_t SegDash  = 8'hBF;

  // store update produced by the decoder
  typedef struct packed {
    logic [NumDigits-1:0]       wr_en;
    seg_t [NumDigits-1:0]       pat;
    logic                       scan;
  } wr_t;

  function automatic seg_t digit_seg(input logic [3:0] d);
    seg_t s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] digit_select(input logic [PtrW-1:0] idx);
    logic [7:0] s;
    unique case (idx)
      2'd0:    s = 8'hF1;
      2'd1:    s = 8'hF2;
      2'd2:    s = 8'hF4;
      default: s = 8'hF8;
    endcase
    return s;
  endfunction

endpackage

// File: sv/ssd_in_if.sv
// ssd_in_if: command channel of the display driver
// depends on nothing
interface ssd_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [15:0] number;
  logic [2:0]         digit_position;
  logic [3:0]         digit_value;

  modport source (output valid, opcode, number, digit_position, digit_value,
                  input ready);
  modport sink   (input valid, opcode, number, digit_position, digit_value,
                  output ready);
endinterface

// File: sv/ssd_out_if.sv
// ssd_out_if: result channel of the display driver
// depends on nothing
interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic       frame_valid;
  logic [7:0] segment_byte;
  logic [7:0] select_byte;
  logic [1:0] scanned_digit;

  modport source (output valid, frame_valid, segment_byte, select_byte,
                  scanned_digit, input ready);
  modport sink   (input valid, frame_valid, segment_byte, select_byte,
                  scanned_digit, output ready);
endinterface

// File: sv/ssd_decode.sv
// ssd_decode: turns one registered command into a digit store update
// depends on ssd_pkg
module ssd_decode (
  input  logic               fire_i,
  input  logic [2:0]         opcode_i,
  input  logic signed [15:0] number_i,
  input  logic [2:0]         digit_position_i,
  input  logic [3:0]         digit_value_i,
  output ssd_pkg::wr_t       wr_o
);

  logic        neg;
  logic        out_of_range;
  logic [15:0] num_abs;
  logic [13:0] mag;
  logic [27:0] prod_k;
  logic [27:0] prod_h;
  logic [27:0] prod_t;
  logic [3:0]  q_k;
  logic [6:0]  q_h;
  logic [9:0]  q_t;
  logic [6:0]  rem_h;
  logic [9:0]  rem_t;
  logic [13:0] rem_u;
  ssd_pkg::seg_t [ssd_pkg::NumDigits-1:0] num_pat;
  logic [3:0]  single_val;
  logic [1:0]  single_idx;
  logic        pos_ok;

  // decimal split by reciprocal multiplication, exact for magnitudes below 10000
  always_comb begin
    neg          = number_i[15];
    out_of_range = (number_i > 16'sd9999) || (number_i < -16'sd999);
    num_abs      = neg ? (~number_i + 16'd1) : number_i;
    mag          = num_abs[13:0];
    prod_k       = {14'd0, mag} * 28'd8389;
    prod_h       = {14'd0, mag} * 28'd5243;
    prod_t       = {14'd0, mag} * 28'd6554;
    q_k          = prod_k[26:23];
    q_h          = prod_h[25:19];
    q_t          = prod_t[25:16];
    rem_h        = q_h - 7'(q_k * 4'd10);
    rem_t        = q_t - 10'(q_h * 7'd10);
    rem_u        = mag - 14'(q_t * 10'd10);

    if (neg) begin
      num_pat[0] = ssd_pkg::SegDash;
    end else if (mag > 14'd999) begin
      num_pat[0] = ssd_pkg::digit_seg(q_k);
    end else begin
      num_pat[0] = ssd_pkg::SegBlank;
    end
    num_pat[1] = (mag > 14'd99) ? ssd_pkg::digit_seg(rem_h[3:0]) : ssd_pkg::SegBlank;
    num_pat[2] = (mag > 14'd9)  ? ssd_pkg::digit_seg(rem_t[3:0]) : ssd_pkg::SegBlank;
    num_pat[3] = ssd_pkg::digit_seg(rem_u[3:0]);
  end

  always_comb begin
    single_val = (digit_value_i > 4'd9) ? (digit_value_i - 4'd10) : digit_value_i;
    pos_ok     = (digit_position_i >= 3'd1) && (digit_position_i <= 3'd4);
    single_idx = 2'(3'd4 - digit_position_i);
  end

  always_comb begin
    wr_o.wr_en = '0;
    wr_o.pat   = '0;
    wr_o.scan  = 1'b0;
    if (fire_i) begin
      unique case (opcode_i)
        ssd_pkg::OP_NUMBER: begin
          wr_o.wr_en = '1;
          if (out_of_range) begin
            wr_o.pat = {ssd_pkg::NumDigits{ssd_pkg::SegDash}};
          end else begin
            wr_o.pat = num_pat;
          end
        end
        ssd_pkg::OP_DIGIT: begin
          if (pos_ok) begin
            wr_o.wr_en[single_idx] = 1'b1;
            wr_o.pat = {ssd_pkg::NumDigits{ssd_pkg::digit_seg(single_val)}};
          end else begin
            wr_o.wr_en = '1;
            wr_o.pat   = {ssd_pkg::NumDigits{ssd_pkg::SegDash}};
          end
        end
        ssd_pkg::OP_BLANK: begin
          wr_o.wr_en = '1;
          wr_o.pat   = {ssd_pkg::NumDigits{ssd_pkg::SegBlank}};
        end
        ssd_pkg::OP_DASH: begin
          wr_o.wr_en = '1;
          wr_o.pat   = {ssd_pkg::NumDigits{ssd_pkg::SegDash}};
        end
        ssd_pkg::OP_SCAN: begin
          wr_o.scan = 1'b1;
        end
        default: begin
          wr_o.scan = 1'b0;
        end
      endcase
    end
  end

endmodule

// File: sv/ssd_store.sv
// ssd_store: four digit pattern registers and the scan pointer
// depends on ssd_pkg
module ssd_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssd_pkg::wr_t                wr_i,
  output ssd_pkg::seg_t               scan_pat_o,
  output logic [ssd_pkg::PtrW-1:0]    scan_ptr_o
);

  ssd_pkg::seg_t [ssd_pkg::NumDigits-1:0] pat_q;
  logic [ssd_pkg::PtrW-1:0]               ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= {ssd_pkg::NumDigits{ssd_pkg::SegBlank}};
      ptr_q <= '0;
    end else begin
      for (int i = 0; i < ssd_pkg::NumDigits; i++) begin
        if (wr_i.wr_en[i]) begin
          pat_q[i] <= wr_i.pat[i];
        end
      end
      if (wr_i.scan) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  assign scan_pat_o = pat_q[ptr_q];
  assign scan_ptr_o = ptr_q;

endmodule

// File: sv/four_digit_seven_segment_driver_core.sv
// four_digit_seven_segment_driver_core: top level of the display driver
// depends on ssd_pkg, ssd_in_if, ssd_out_if, ssd_decode, ssd_store
//
// usage:
//   in_i carries one command per transfer: write a number, set one digit,
//   blank all, dash all, or a scan tick. out_o returns exactly one result
//   per command; only a scan tick sets frame_valid and carries the segment
//   byte, select byte and index of the digit under the scan pointer, other
//   results carry zeros.
//   a command is held in an input register, then decoded combinationally
//   (decimal split by constant reciprocals, segment table) into the digit
//   store and the result register. throughput is one command per cycle
//   while out_o is not stalled.
//   while out_o is stalled the input register still takes one more command,
//   then in_i.ready drops until the result is taken.
//   reset blanks all digits, clears the scan pointer and empties both
//   registers.
module four_digit_seven_segment_driver_core (
  input  logic clk_i,
  input  logic rst_ni,
  ssd_in_if.sink    in_i,
  ssd_out_if.source out_o
);

  logic               s1_valid_q;
  logic [2:0]         s1_opcode_q;
  logic signed [15:0] s1_number_q;
  logic [2:0]         s1_pos_q;
  logic [3:0]         s1_val_q;

  logic               out_valid_q;
  logic               frame_q;
  logic [7:0]         seg_q;
  logic [7:0]         sel_q;
  logic [1:0]         dig_q;

  logic               advance;
  logic               fire;
  ssd_pkg::wr_t       wr;
  ssd_pkg::seg_t      scan_pat;
  logic [ssd_pkg::PtrW-1:0] scan_ptr;

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_opcode_q <= in_i.opcode;
      s1_number_q <= in_i.number;
      s1_pos_q    <= in_i.digit_position;
      s1_val_q    <= in_i.digit_value;
    end
  end

  ssd_decode u_decode (
    .fire_i           (fire),
    .opcode_i         (s1_opcode_q),
    .number_i         (s1_number_q),
    .digit_position_i (s1_pos_q),
    .digit_value_i    (s1_val_q),
    .wr_o             (wr)
  );

  ssd_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .scan_pat_o (scan_pat),
    .scan_ptr_o (scan_ptr)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      frame_q <= wr.scan;
      seg_q   <= wr.scan ? scan_pat : 8'h00;
      sel_q   <= wr.scan ? ssd_pkg::digit_select(scan_ptr) : 8'h00;
      dig_q   <= wr.scan ? scan_ptr : 2'd0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.frame_valid   = frame_q;
  assign out_o.segment_byte  = seg_q;
  assign out_o.select_byte   = sel_q;
  assign out_o.scanned_digit = dig_q;

endmodule
